// ----- src/scc_pkg.sv -----
// Shared types, codes and the coil table of the calibrating shuttle controller.
package scc_pkg;

  // Field widths of the stream items and the configuration registers.
  localparam int unsigned NowW     = 32;
  localparam int unsigned ButtonW  = 2;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned CoilW    = 4;
  localparam int unsigned PhaseW   = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 16;

  // Operating modes as reported on the result stream.
  localparam logic [ModeW-1:0] MODE_IDLE     = 2'd0;
  localparam logic [ModeW-1:0] MODE_ARMED    = 2'd1;
  localparam logic [ModeW-1:0] MODE_COUNTING = 2'd2;
  localparam logic [ModeW-1:0] MODE_RUNNING  = 2'd3;

  // Button event codes; the unused code counts as no event.
  localparam logic [ButtonW-1:0] BTN_NONE  = 2'd0;
  localparam logic [ButtonW-1:0] BTN_PRESS = 2'd1;
  localparam logic [ButtonW-1:0] BTN_LONG  = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_STEP_INTERVAL  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_BLINK_INTERVAL = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_DWELL          = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [CfgDataW-1:0] STEP_INTERVAL_RST  = 32'd2000;
  localparam logic [CfgDataW-1:0] BLINK_INTERVAL_RST = 32'd250000;
  localparam logic [CfgDataW-1:0] DWELL_RST          = 32'd3000000;

  // Current configuration as seen by the controller core.
  typedef struct packed {
    logic [CfgDataW-1:0] step_interval_us;
    logic [CfgDataW-1:0] blink_interval_us;
    logic [CfgDataW-1:0] dwell_us;
  } cfg_t;

  // One result transaction.
  typedef struct packed {
    logic             dwelling;
    logic             heading_down;
    logic             stepped;
    logic [CoilW-1:0] coil_drive;
    logic             led_on;
    logic [ModeW-1:0] mode;
  } result_t;

  // Standard four-coil half-step sequence.
  function automatic logic [CoilW-1:0] coil_pattern(input logic [PhaseW-1:0] phase);
    logic [CoilW-1:0] pat;
    case (phase)
      3'd0:    pat = 4'd1;
      3'd1:    pat = 4'd3;
      3'd2:    pat = 4'd2;
      3'd3:    pat = 4'd6;
      3'd4:    pat = 4'd4;
      3'd5:    pat = 4'd12;
      3'd6:    pat = 4'd8;
      default: pat = 4'd9;
    endcase
    return pat;
  endfunction

endpackage

// ----- src/scc_cfg_regs.sv -----
// Configuration register file of the calibrating shuttle controller.
module scc_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [scc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [scc_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output scc_pkg::cfg_t                 cfg_o
);
  import scc_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Decode the write; an index past the last register is dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_STEP_INTERVAL:  cfg_d.step_interval_us  = cfg_wdata_i;
        REG_BLINK_INTERVAL: cfg_d.blink_interval_us = cfg_wdata_i;
        REG_DWELL:          cfg_d.dwell_us          = cfg_wdata_i;
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_interval_us  <= STEP_INTERVAL_RST;
      cfg_q.blink_interval_us <= BLINK_INTERVAL_RST;
      cfg_q.dwell_us          <= DWELL_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- src/scc_core.sv -----
// Controller state and the per-tick update of mode, LED, coils and travel counters.
module scc_core #(
  parameter int unsigned STEP_COUNT_BITS = 24,
  parameter int unsigned TIME_BITS       = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         tick_i,
  input  logic [scc_pkg::NowW-1:0]     now_us_i,
  input  logic [scc_pkg::ButtonW-1:0]  button_i,
  input  scc_pkg::cfg_t                cfg_i,
  output scc_pkg::result_t             result_o
);
  import scc_pkg::*;

  // Time differences are compared at the wider of the time and interval widths.
  localparam int unsigned CmpW = (TIME_BITS > CfgDataW) ? TIME_BITS : CfgDataW;

  logic [ModeW-1:0]           mode_q, mode_d;
  logic                       led_q, led_d;
  logic [TIME_BITS-1:0]       last_step_q, last_step_d;
  logic [TIME_BITS-1:0]       last_blink_q, last_blink_d;
  logic [TIME_BITS-1:0]       dwell_start_q, dwell_start_d;
  logic [PhaseW-1:0]          phase_q, phase_d;
  logic [STEP_COUNT_BITS-1:0] travel_q, travel_d;
  logic [STEP_COUNT_BITS-1:0] left_q, left_d;
  logic                       down_q, down_d;
  logic                       dwell_q, dwell_d;
  logic [CoilW-1:0]           coil_q, coil_d;

  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] step_diff, blink_diff, dwell_diff;
  logic                 step_due, blink_due, dwell_done;
  logic                 press;
  logic [ModeW-1:0]     mode_eff;
  logic                 stepped;

  // Wrapping time differences against the programmed spans.
  assign now_t      = TIME_BITS'(now_us_i);
  assign step_diff  = now_t - last_step_q;
  assign blink_diff = now_t - last_blink_q;
  assign dwell_diff = now_t - dwell_start_q;
  assign step_due   = CmpW'(step_diff)  >= CmpW'(cfg_i.step_interval_us);
  assign blink_due  = CmpW'(blink_diff) >= CmpW'(cfg_i.blink_interval_us);
  assign dwell_done = CmpW'(dwell_diff) >= CmpW'(cfg_i.dwell_us);

  assign press    = (button_i == BTN_PRESS);
  assign mode_eff = (button_i == BTN_LONG) ? MODE_ARMED : mode_q;

  // Next state for one tick.
  always_comb begin
    mode_d        = mode_eff;
    led_d         = led_q;
    last_step_d   = last_step_q;
    last_blink_d  = last_blink_q;
    dwell_start_d = dwell_start_q;
    phase_d       = phase_q;
    travel_d      = travel_q;
    left_d        = left_q;
    down_d        = down_q;
    dwell_d       = dwell_q;
    coil_d        = coil_q;
    stepped       = 1'b0;
    unique case (mode_eff)
      MODE_IDLE: begin
        if (press && (travel_q != '0)) begin
          led_d   = 1'b0;
          dwell_d = 1'b0;
          mode_d  = MODE_RUNNING;
        end
      end
      MODE_ARMED: begin
        led_d = 1'b1;
        if (press) begin
          travel_d    = '0;
          left_d      = '0;
          last_step_d = now_t;
          mode_d      = MODE_COUNTING;
        end
      end
      MODE_COUNTING: begin
        if (press) begin
          left_d  = travel_q;
          down_d  = 1'b1;
          dwell_d = 1'b0;
          led_d   = 1'b0;
          mode_d  = MODE_RUNNING;
        end else begin
          if (blink_due) begin
            last_blink_d = now_t;
            led_d        = ~led_q;
          end
          // Calibration always steps upward.
          if (step_due) begin
            stepped     = 1'b1;
            coil_d      = coil_pattern(phase_q);
            phase_d     = phase_q - 1'b1;
            last_step_d = now_t;
            travel_d    = travel_q + 1'b1;
          end
        end
      end
      default: begin
        if (!dwell_q) begin
          if (step_due) begin
            stepped     = 1'b1;
            coil_d      = coil_pattern(phase_q);
            phase_d     = down_q ? (phase_q + 1'b1) : (phase_q - 1'b1);
            last_step_d = now_t;
            left_d      = left_q - 1'b1;
          end
        end else if (dwell_done) begin
          dwell_d = 1'b0;
        end
        // End of travel: reload, turn around and start the dwell.
        if (left_d == '0) begin
          left_d        = travel_q;
          down_d        = ~down_q;
          dwell_d       = 1'b1;
          dwell_start_d = now_t;
        end
        if (press) begin
          mode_d = MODE_IDLE;
          coil_d = '0;
        end
      end
    endcase
  end

  // State registers advance once per tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= MODE_IDLE;
      led_q         <= 1'b0;
      last_step_q   <= '0;
      last_blink_q  <= '0;
      dwell_start_q <= '0;
      phase_q       <= '0;
      travel_q      <= '0;
      left_q        <= '0;
      down_q        <= 1'b0;
      dwell_q       <= 1'b0;
      coil_q        <= '0;
    end else if (tick_i) begin
      mode_q        <= mode_d;
      led_q         <= led_d;
      last_step_q   <= last_step_d;
      last_blink_q  <= last_blink_d;
      dwell_start_q <= dwell_start_d;
      phase_q       <= phase_d;
      travel_q      <= travel_d;
      left_q        <= left_d;
      down_q        <= down_d;
      dwell_q       <= dwell_d;
      coil_q        <= coil_d;
    end
  end

  // Result of this tick, taken into the output register by the top level.
  always_comb begin
    result_o.mode         = mode_d;
    result_o.led_on       = led_d;
    result_o.coil_drive   = coil_d;
    result_o.stepped      = stepped;
    result_o.heading_down = down_d;
    result_o.dwelling     = dwell_d;
  end

endmodule

// ----- src/stepper_shuttle_calibrating_controller_unit.sv -----
// Calibrating stepper shuttle controller: usage
// Each input transaction on the s_axis channel is one tick: a wrapping microsecond
// timestamp and a button event. Every tick yields exactly one result transaction on
// the m_axis channel carrying mode, LED level, held coil pattern, a step strobe,
// the travel direction and the dwell flag.
// Timing: an accepted tick is held in an input register while the controller core
// works on it, and its result is loaded into the output register once that register
// is free or drains, so a result passes the input register and then the output
// register. One tick is taken every cycle while m_axis_tready stays high.
// Backpressure: while the receiver holds m_axis_tready low, the result stays on
// m_axis and one more tick can still be taken into the input register; after that
// s_axis_tready drops until the receiver takes the result.
// Configuration: cfg_we_i writes register cfg_idx_i (0 step interval, 1 blink
// interval, 2 dwell time) in the same cycle; write only while no tick is in flight.
// Reset: asynchronous and active low; both channels empty, mode idle, LED and coils
// off, counters and timestamps zero, intervals at 2000, 250000 and 3000000 us.
module stepper_shuttle_calibrating_controller_unit #(
  parameter int unsigned STEP_COUNT_BITS = 24,
  parameter int unsigned TIME_BITS       = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input ticks.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: now_us [31:0], button [33:32], zero fill [39:34]
  input  logic [scc_pkg::InDataW-1:0]    s_axis_tdata,
  // Results.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata: mode [1:0], led_on [2], coil_drive [6:3], stepped [7], heading_down [8],
  // dwelling [9], zero fill [15:10]
  output logic [scc_pkg::OutDataW-1:0]   m_axis_tdata,
  // Configuration writes.
  input  logic                           cfg_we_i,
  input  logic [scc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [scc_pkg::CfgDataW-1:0]   cfg_wdata_i
);
  import scc_pkg::*;

  logic                in_valid_q, in_valid_d;
  logic [NowW-1:0]     now_q;
  logic [ButtonW-1:0]  button_q;
  logic                out_valid_q, out_valid_d;
  result_t             result_q;
  result_t             result_d;
  cfg_t                cfg;
  logic                advance;
  logic                in_accept;

  // Handshake: the held tick advances when the output register is free or drains.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  assign in_valid_d  = in_accept ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign out_valid_d = advance ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      now_q    <= s_axis_tdata[NowW-1:0];
      button_q <= s_axis_tdata[NowW+ButtonW-1:NowW];
    end
  end

  scc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  scc_core #(
    .STEP_COUNT_BITS (STEP_COUNT_BITS),
    .TIME_BITS       (TIME_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tick_i   (advance),
    .now_us_i (now_q),
    .button_i (button_q),
    .cfg_i    (cfg),
    .result_o (result_d)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OutDataW - $bits(result_t))'(0), result_q};

endmodule

// ----- src/scc_checker.sv -----
// Port-level checks of the calibrating shuttle controller and their bind.
module scc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [scc_pkg::OutDataW-1:0] m_axis_tdata
);
  import scc_pkg::*;

  logic [ModeW-1:0] mode;
  logic [CoilW-1:0] coil;
  logic             stepped;

  assign mode    = m_axis_tdata[ModeW-1:0];
  assign coil    = m_axis_tdata[ModeW+CoilW:ModeW+1];
  assign stepped = m_axis_tdata[ModeW+CoilW+1];

  // A stalled result transaction keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // With the output register empty the block never stalls the sender.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // Idle is only reached from reset or a stop, both of which release the coils.
  a_idle_coils_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (mode == MODE_IDLE) |-> (coil == '0))
    else $error("coils driven in idle");

  // A step is never reported in the armed mode; a stop may end a stepping tick in idle.
  a_step_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && stepped |-> (mode != MODE_ARMED))
    else $error("step reported while armed");

endmodule

bind stepper_shuttle_calibrating_controller_unit scc_checker u_scc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
